[rtl/pfre_pkg.sv]
// Shared types and constants for the page frame store raster engine.
package pfre_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_SIZE    = PAGE_COUNT * SCREEN_WIDTH;
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W        = $clog2(STORE_SIZE);

    typedef enum logic [2:0] {
        OP_LINE_SET   = 3'd0,
        OP_LINE_CLR   = 3'd1,
        OP_RECT_FILL  = 3'd2,
        OP_RECT_CLR   = 3'd3,
        OP_CIRCLE     = 3'd4,
        OP_READ       = 3'd5,
        OP_RSVD6      = 3'd6,
        OP_RSVD7      = 3'd7
    } t_op;

    // Classified command handed from front to back.
    typedef struct packed {
        t_op        op;
        logic       reject;
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] rad;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE_PIX,
        ST_CIRC_PIX,
        ST_RECT_PIX,
        ST_READ_WAIT,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DONE
    } t_state;

endpackage

[rtl/pfre_front.sv]
// Front end: bounds checks on incoming commands and a two-entry command queue.
module pfre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_coord_x,
    input  logic [7:0]        i_coord_y,
    input  logic [7:0]        i_extent_x,
    input  logic [7:0]        i_extent_y,
    input  logic [7:0]        i_radius,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output pfre_pkg::t_cmd    o_cmd
);
    localparam int W = pfre_pkg::SCREEN_WIDTH;
    localparam int H = pfre_pkg::SCREEN_HEIGHT;

    pfre_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    pfre_pkg::t_cmd n_cmd;
    logic           rej;
    logic [8:0]     xw, yh;
    logic [9:0]     cxr, cyr;
    logic           push, pop;

    assign xw  = {1'b0, i_coord_x} + {1'b0, i_extent_x};
    assign yh  = {1'b0, i_coord_y} + {1'b0, i_extent_y};
    assign cxr = {2'b00, i_coord_x} + {2'b00, i_radius};
    assign cyr = {2'b00, i_coord_y} + {2'b00, i_radius};

    always_comb begin
        case (pfre_pkg::t_op'(i_operation))
            pfre_pkg::OP_LINE_SET, pfre_pkg::OP_LINE_CLR:
                rej = (32'(i_coord_x) > W - 1) || (32'(i_extent_x) > W - 1) ||
                      (32'(i_coord_y) > H - 1) || (32'(i_extent_y) > H - 1);
            pfre_pkg::OP_RECT_FILL, pfre_pkg::OP_RECT_CLR:
                rej = (32'(xw) > W - 1) || (32'(yh) > H - 1);
            pfre_pkg::OP_CIRCLE:
                rej = (i_radius > i_coord_x) || (i_radius > i_coord_y) ||
                      (32'(cxr) > W - 1) || (32'(cyr) > H - 1);
            pfre_pkg::OP_READ:
                rej = (32'(i_coord_x) >= W) || (32'(i_coord_y) >= pfre_pkg::PAGE_COUNT);
            default:
                rej = 1'b1;
        endcase
        n_cmd.op     = pfre_pkg::t_op'(i_operation);
        n_cmd.reject = rej;
        n_cmd.cx     = i_coord_x;
        n_cmd.cy     = i_coord_y;
        n_cmd.ex     = i_extent_x;
        n_cmd.ey     = i_extent_y;
        n_cmd.rad    = i_radius;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
    end
endmodule

[rtl/pfre_back.sv]
// Back end: frame store, line/circle/rectangle sequencer and result register.
module pfre_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  pfre_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_status,
    output logic [7:0]        o_read_data
);
    localparam int AW = pfre_pkg::ADDR_W;
    localparam int CW = pfre_pkg::COL_W;
    localparam int PW = pfre_pkg::PAGE_W;

    logic [7:0] r_mem [pfre_pkg::STORE_SIZE];
    logic [7:0] r_rdata;

    pfre_pkg::t_state r_st, n_st, r_ret, n_ret;
    pfre_pkg::t_cmd   r_c, n_c;
    // line / circle working registers (signed, wide enough for the errors)
    logic signed [10:0] r_x, n_x, r_y, n_y, r_err, n_err, r_dx, n_dx, r_dy, n_dy;
    logic [2:0]  r_oct, n_oct;
    logic [7:0]  r_col, n_col;
    logic [PW-1:0] r_pg, n_pg;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]  r_bits, n_bits;
    logic        r_set, n_set;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_ov, n_ov;
    logic        r_os, n_os;
    logic [7:0]  r_od, n_od;

    logic        we;
    logic [AW-1:0] waddr;
    logic [7:0]  wdata;
    logic [63:0] mask;
    logic signed [10:0] px, py, e2;

    assign mask = ((64'd1 << r_c.ey[5:0]) - 64'd1) << r_c.cy[5:0];

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= pfre_pkg::ST_CLEAR;
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret; r_c <= n_c; r_x <= n_x; r_y <= n_y; r_err <= n_err;
        r_dx <= n_dx; r_dy <= n_dy; r_oct <= n_oct; r_col <= n_col; r_pg <= n_pg;
        r_addr <= n_addr; r_bits <= n_bits; r_set <= n_set; r_os <= n_os; r_od <= n_od;
    end

    assign o_valid     = r_ov;
    assign o_status    = r_os;
    assign o_read_data = r_od;

    always_comb begin
        n_st = r_st; n_ret = r_ret; n_c = r_c; n_x = r_x; n_y = r_y; n_err = r_err;
        n_dx = r_dx; n_dy = r_dy; n_oct = r_oct; n_col = r_col; n_pg = r_pg;
        n_addr = r_addr; n_bits = r_bits; n_set = r_set; n_clr = r_clr;
        n_ov = r_ov; n_os = r_os; n_od = r_od;
        we = 1'b0; waddr = r_addr; wdata = '0;
        o_cmd_ready = 1'b0;
        px = '0; py = '0; e2 = r_err;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            pfre_pkg::ST_CLEAR: begin
                we = 1'b1; waddr = r_clr; wdata = '0;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == pfre_pkg::STORE_SIZE - 1) n_st = pfre_pkg::ST_IDLE;
            end
            pfre_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_c = i_cmd;
                    if (i_cmd.reject) begin
                        n_st = pfre_pkg::ST_DONE;
                    end else begin
                        case (i_cmd.op)
                            pfre_pkg::OP_LINE_SET, pfre_pkg::OP_LINE_CLR: begin
                                n_x = 11'(i_cmd.cx); n_y = 11'(i_cmd.cy);
                                n_dx = (i_cmd.ex > i_cmd.cx) ? 11'(i_cmd.ex - i_cmd.cx)
                                                             : 11'(i_cmd.cx - i_cmd.ex);
                                n_dy = (i_cmd.ey > i_cmd.cy) ? 11'(i_cmd.ey - i_cmd.cy)
                                                             : 11'(i_cmd.cy - i_cmd.ey);
                                n_err = (n_dx > n_dy) ? (n_dx >>> 1) : -(n_dy >>> 1);
                                n_set = (i_cmd.op == pfre_pkg::OP_LINE_SET);
                                n_st = pfre_pkg::ST_LINE_PIX;
                            end
                            pfre_pkg::OP_RECT_FILL, pfre_pkg::OP_RECT_CLR: begin
                                n_col = i_cmd.cx; n_pg = '0;
                                n_set = (i_cmd.op == pfre_pkg::OP_RECT_FILL);
                                n_st = pfre_pkg::ST_RECT_PIX;
                            end
                            pfre_pkg::OP_CIRCLE: begin
                                n_x = 11'(i_cmd.rad); n_y = '0;
                                n_dx = 11'sd1; n_dy = 11'sd1;
                                n_err = 11'sd1 - (11'(i_cmd.rad) <<< 1);
                                n_oct = '0; n_set = 1'b1;
                                n_st = pfre_pkg::ST_CIRC_PIX;
                            end
                            default: begin
                                n_addr = AW'(i_cmd.cy[PW-1:0]) * AW'(pfre_pkg::SCREEN_WIDTH)
                                         + AW'(i_cmd.cx[CW-1:0]);
                                n_st = pfre_pkg::ST_READ_WAIT;
                            end
                        endcase
                    end
                end
            end
            pfre_pkg::ST_LINE_PIX: begin
                // issue current pixel, then step
                n_addr = AW'(r_y[5:3]) * AW'(pfre_pkg::SCREEN_WIDTH) + AW'(r_x[CW-1:0]);
                n_bits = 8'd1 << r_y[2:0];
                n_ret  = pfre_pkg::ST_LINE_PIX;
                if (r_x == 11'(r_c.ex) && r_y == 11'(r_c.ey)) n_ret = pfre_pkg::ST_DONE;
                if (e2 > -r_dx) begin
                    n_err = r_err - r_dy;
                    n_x = (r_c.cx < r_c.ex) ? r_x + 11'sd1 : r_x - 11'sd1;
                end
                if (e2 < r_dy) begin
                    n_err = n_err + r_dx;
                    n_y = (r_c.cy < r_c.ey) ? r_y + 11'sd1 : r_y - 11'sd1;
                end
                if (n_ret == pfre_pkg::ST_DONE) begin
                    n_x = r_x; n_y = r_y; n_err = r_err;
                end
                n_st = pfre_pkg::ST_RMW_RD;
            end
            pfre_pkg::ST_CIRC_PIX: begin
                if (r_x < r_y) begin
                    n_st = pfre_pkg::ST_DONE;
                end else begin
                    case (r_oct)
                        3'd0: begin px = r_x;  py = r_y;  end
                        3'd1: begin px = r_y;  py = r_x;  end
                        3'd2: begin px = -r_y; py = r_x;  end
                        3'd3: begin px = -r_x; py = r_y;  end
                        3'd4: begin px = -r_x; py = -r_y; end
                        3'd5: begin px = -r_y; py = -r_x; end
                        3'd6: begin px = r_y;  py = -r_x; end
                        default: begin px = r_x; py = -r_y; end
                    endcase
                    px = px + 11'(r_c.cx);
                    py = py + 11'(r_c.cy);
                    n_addr = AW'(py[5:3]) * AW'(pfre_pkg::SCREEN_WIDTH) + AW'(px[CW-1:0]);
                    n_bits = 8'd1 << py[2:0];
                    n_oct  = r_oct + 3'd1;
                    n_ret  = pfre_pkg::ST_CIRC_PIX;
                    if (r_oct == 3'd7) begin
                        n_err = r_err;
                        if (r_err <= 0) begin
                            n_y = r_y + 11'sd1;
                            n_err = r_err + r_dy;
                            n_dy = r_dy + 11'sd2;
                        end
                        if (n_err > 0) begin
                            n_x = r_x - 11'sd1;
                            n_dx = r_dx + 11'sd2;
                            n_err = n_err + n_dx - (11'(r_c.rad) <<< 1);
                        end
                    end
                    n_st = pfre_pkg::ST_RMW_RD;
                end
            end
            pfre_pkg::ST_RECT_PIX: begin
                if (r_col >= r_c.cx + r_c.ex || r_c.ex == 8'd0) begin
                    n_st = pfre_pkg::ST_DONE;
                end else begin
                    n_addr = AW'(r_pg) * AW'(pfre_pkg::SCREEN_WIDTH) + AW'(r_col[CW-1:0]);
                    n_bits = mask[{r_pg, 3'b000} +: 8];
                    n_ret  = pfre_pkg::ST_RECT_PIX;
                    if (32'(r_pg) == pfre_pkg::PAGE_COUNT - 1) begin
                        n_pg = '0; n_col = r_col + 8'd1;
                    end else begin
                        n_pg = r_pg + 1'b1;
                    end
                    n_st = pfre_pkg::ST_RMW_RD;
                end
            end
            pfre_pkg::ST_RMW_RD: n_st = pfre_pkg::ST_RMW_WR;
            pfre_pkg::ST_RMW_WR: begin
                we = 1'b1; waddr = r_addr;
                wdata = r_set ? (r_rdata | r_bits) : (r_rdata & ~r_bits);
                n_st = r_ret;
            end
            pfre_pkg::ST_READ_WAIT: begin
                n_st = pfre_pkg::ST_RMW_RD;
                n_ret = pfre_pkg::ST_DONE;
                n_set = 1'b1; n_bits = '0;
            end
            pfre_pkg::ST_DONE: begin
                // load the result register only once it is free
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_os = r_c.reject;
                    n_od = (r_c.op == pfre_pkg::OP_READ && !r_c.reject) ? r_rdata : 8'd0;
                    n_st = pfre_pkg::ST_IDLE;
                end
            end
            default: n_st = pfre_pkg::ST_IDLE;
        endcase
    end
endmodule

[rtl/page_framebuffer_raster_engine_top.sv]
// Top level of the page frame store raster engine.
// Draws lines, rectangles and circle outlines into a 128x64 monochrome store of
// 8-row pages and reads back single page bytes; one status result per command.
// After reset the store is swept to zero, one byte a cycle, all 1024 bytes, before
// the first command runs. Each pixel (or page byte of a rectangle) is one
// read-modify-write on the frame store, through the drawing state, ST_RMW_RD
// and ST_RMW_WR. A line writes one pixel per step, a circle eight points per
// step of the midpoint loop and a rectangle every page byte of each column.
// Commands queue two deep ahead of the sequencer.
module page_framebuffer_raster_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_coord_x,
    input  logic [7:0] i_coord_y,
    input  logic [7:0] i_extent_x,
    input  logic [7:0] i_extent_y,
    input  logic [7:0] i_radius,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_status,
    output logic [7:0] o_read_data
);
    logic           cmd_valid, cmd_ready;
    pfre_pkg::t_cmd cmd;

    pfre_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_coord_x, .i_coord_y,
        .i_extent_x, .i_extent_y, .i_radius,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    pfre_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_status, .o_read_data
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_read_data))
        else $error("result changed while stalled");
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_read_data == 8'd0)
        else $error("rejected command carries data");
endmodule

[tb/tb_page_framebuffer_raster_engine_top.sv]
// Self-checking testbench for the page frame store raster engine.
module tb_page_framebuffer_raster_engine_top;
    import pfre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       status;
        logic [7:0] data;
    } t_result;

    class raster_scoreboard;
        logic [7:0] store [STORE_SIZE];
        t_result    pending [$];
        int         errors;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            errors = 0;
        endfunction

        function void put_pixel(int px, int py, bit set);
            int idx;
            if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) return;
            idx = (py / 8) * SCREEN_WIDTH + px;
            if (set) store[idx][py % 8] = 1'b1;
            else     store[idx][py % 8] = 1'b0;
        endfunction

        function bit draw_line(int x0, int y0, int x1, int y1, bit set);
            int dx, dy, sx, sy, err, e2;
            if (x0 > SCREEN_WIDTH - 1 || x1 > SCREEN_WIDTH - 1 ||
                y0 > SCREEN_HEIGHT - 1 || y1 > SCREEN_HEIGHT - 1) return 0;
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = (dx > dy) ? dx / 2 : -(dy / 2);
            forever begin
                put_pixel(x0, y0, set);
                if (x0 == x1 && y0 == y1) break;
                e2 = err;
                if (e2 > -dx) begin
                    err -= dy;
                    x0 += sx;
                end
                if (e2 < dy) begin
                    err += dx;
                    y0 += sy;
                end
            end
            return 1;
        endfunction

        function bit draw_rect(int x, int y, int w, int h, bit set);
            logic [63:0] mask;
            logic [7:0]  m;
            int idx;
            if (x + w > SCREEN_WIDTH - 1 || y + h > SCREEN_HEIGHT - 1) return 0;
            mask = ((64'd1 << h) - 64'd1) << y;
            for (int col = x; col < x + w; col++) begin
                for (int pg = 0; pg < PAGE_COUNT; pg++) begin
                    m = mask[pg*8 +: 8];
                    idx = pg * SCREEN_WIDTH + col;
                    store[idx] = set ? (store[idx] | m) : (store[idx] & ~m);
                end
            end
            return 1;
        endfunction

        function bit draw_circle(int cx, int cy, int r);
            int x, y, dx, dy, err;
            if (r > cx || r > cy || (SCREEN_WIDTH - 1 - r) < cx ||
                (SCREEN_HEIGHT - 1 - r) < cy) return 0;
            x = r; y = 0; dx = 1; dy = 1;
            err = dx - 2 * r;
            while (x >= y) begin
                put_pixel(cx + x, cy + y, 1);
                put_pixel(cx + y, cy + x, 1);
                put_pixel(cx - y, cy + x, 1);
                put_pixel(cx - x, cy + y, 1);
                put_pixel(cx - x, cy - y, 1);
                put_pixel(cx - y, cy - x, 1);
                put_pixel(cx + y, cy - x, 1);
                put_pixel(cx + x, cy - y, 1);
                if (err <= 0) begin
                    y++;
                    err += dy;
                    dy += 2;
                end
                if (err > 0) begin
                    x--;
                    dx += 2;
                    err += dx - 2 * r;
                end
            end
            return 1;
        endfunction

        function void note_command(t_op op, int cx, int cy, int ex, int ey, int rad);
            bit         ok;
            logic [7:0] data;
            t_result    res;
            ok = 0;
            data = 8'h00;
            case (op)
                OP_LINE_SET:  ok = draw_line(cx, cy, ex, ey, 1);
                OP_LINE_CLR:  ok = draw_line(cx, cy, ex, ey, 0);
                OP_RECT_FILL: ok = draw_rect(cx, cy, ex, ey, 1);
                OP_RECT_CLR:  ok = draw_rect(cx, cy, ex, ey, 0);
                OP_CIRCLE:    ok = draw_circle(cx, cy, rad);
                OP_READ: begin
                    if (cx < SCREEN_WIDTH && cy < PAGE_COUNT) begin
                        data = store[cy * SCREEN_WIDTH + cx];
                        ok = 1;
                    end
                end
                default: ok = 0;
            endcase
            res.status = ok ? 1'b0 : 1'b1;
            res.data   = ok ? data : 8'h00;
            pending.push_back(res);
        endfunction

        function void check_result(logic status, logic [7:0] data);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%02h", $time, status, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: read_data expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_operation = '0;
    logic [7:0] i_coord_x = '0;
    logic [7:0] i_coord_y = '0;
    logic [7:0] i_extent_x = '0;
    logic [7:0] i_extent_y = '0;
    logic [7:0] i_radius = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_status;
    logic [7:0] o_read_data;

    raster_scoreboard sb;
    bit  long_hold = 0;
    bit  sending_done = 0;
    int  idle_cycles = 0;
    localparam int WATCHDOG_LIMIT = 40000;

    page_framebuffer_raster_engine_top u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Compare every result transfer and count cycles with no transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_status, o_read_data);
            if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver stall pattern; the long hold-off overrides it.
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (long_hold) i_ready <= 1'b0;
            else if ((phase / 64) % 3 == 0) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_command(logic [2:0] op, logic [7:0] cx, logic [7:0] cy,
                                logic [7:0] ex, logic [7:0] ey, logic [7:0] rad);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_coord_x   <= cx;
        i_coord_y   <= cy;
        i_extent_x  <= ex;
        i_extent_y  <= ey;
        i_radius    <= rad;
        do @(posedge i_clk); while (!o_ready);
        sb.note_command(t_op'(op), cx, cy, ex, ey, rad);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [2:0] op;
        logic [7:0] cx, cy, ex, ey, rad;
        int pick;
        op  = $urandom_range(0, 7);
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            // mostly in-bounds, small shapes
            op  = (pick < 7) ? $urandom_range(0, 5) : op;
            cx  = $urandom_range(0, SCREEN_WIDTH - 1);
            cy  = $urandom_range(0, SCREEN_HEIGHT - 1);
            case (op)
                OP_LINE_SET, OP_LINE_CLR: begin
                    ex = $urandom_range(0, SCREEN_WIDTH - 1);
                    ey = $urandom_range(0, SCREEN_HEIGHT - 1);
                    if ($urandom_range(0, 1)) begin
                        ex = (cx + $urandom_range(0, 12)) % SCREEN_WIDTH;
                        ey = (cy + $urandom_range(0, 12)) % SCREEN_HEIGHT;
                    end
                end
                OP_RECT_FILL, OP_RECT_CLR: begin
                    ex = $urandom_range(0, 6);
                    ey = $urandom_range(0, SCREEN_HEIGHT - 1 - cy);
                    if (cx + ex > SCREEN_WIDTH - 1) cx = SCREEN_WIDTH - 1 - ex;
                end
                OP_READ: begin
                    cy = $urandom_range(0, PAGE_COUNT);
                    ex = $urandom; ey = $urandom;
                end
                default: begin
                    ex = $urandom; ey = $urandom;
                end
            endcase
            rad = $urandom_range(0, 12);
        end else begin
            cx = $urandom; cy = $urandom; ex = $urandom; ey = $urandom; rad = $urandom;
        end
        send_command(op, cx, cy, ex, ey, rad);
    endtask

    initial begin
        int count;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each operation and each bound case
        send_command(OP_READ, 0, 0, 0, 0, 0);
        send_command(OP_LINE_SET, 0, 0, 127, 63, 0);
        send_command(OP_LINE_SET, 127, 0, 0, 63, 0);
        send_command(OP_LINE_SET, 10, 50, 20, 5, 0);
        send_command(OP_LINE_SET, 5, 5, 5, 5, 0);
        send_command(OP_LINE_CLR, 0, 0, 127, 63, 0);
        send_command(OP_LINE_SET, 128, 0, 0, 0, 0);
        send_command(OP_LINE_SET, 0, 0, 0, 64, 0);
        send_command(OP_RECT_FILL, 0, 0, 8, 62, 0);
        send_command(OP_RECT_FILL, 120, 0, 7, 10, 0);
        send_command(OP_RECT_FILL, 121, 0, 7, 10, 0);
        send_command(OP_RECT_FILL, 0, 1, 4, 62, 0);
        send_command(OP_RECT_FILL, 30, 10, 0, 5, 0);
        send_command(OP_RECT_FILL, 30, 10, 5, 0, 0);
        send_command(OP_RECT_CLR, 2, 3, 3, 20, 0);
        send_command(OP_CIRCLE, 40, 30, 0, 0, 0);
        send_command(OP_CIRCLE, 63, 31, 0, 0, 31);
        send_command(OP_CIRCLE, 31, 31, 0, 0, 32);
        send_command(OP_CIRCLE, 255, 255, 255, 255, 255);
        send_command(OP_READ, 127, 7, 0, 0, 0);
        send_command(OP_READ, 128, 0, 0, 0, 0);
        send_command(OP_READ, 0, 8, 0, 0, 0);
        send_command(OP_RSVD6, 1, 1, 1, 1, 1);
        send_command(OP_RSVD7, 255, 255, 255, 255, 255);
        send_command(OP_READ, 3, 1, 0, 0, 0);

        count = 0;
        while (count < 2000) begin
            int burst;
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                send_random();
                count++;
            end
            if (count > 600 && count < 640 && !long_hold) begin
                // hold the receiver off while the sender keeps offering
                fork
                    begin
                        long_hold = 1;
                        repeat (3000) @(posedge i_clk);
                        long_hold = 0;
                    end
                join_none
            end
            if (count > 1200 && count < 1221) begin
                i_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end
        i_valid <= 1'b0;
        sending_done = 1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
